FILE: hw/rtl/lut3d_pkg.sv
// lut3d_pkg: shared constants and opcodes for the 3D LUT trilinear sampler.
// No dependencies.
`timescale 1ns / 1ps

package lut3d_pkg;

    localparam int DEF_MAX_GRID  = 33;
    localparam int DEF_FRAC_BITS = 16;
    localparam int IDX_W         = 6;   // grid index ports
    localparam int SIZE_W        = 6;   // lut_size register

    typedef enum logic {
        OP_WRITE  = 1'b0,
        OP_SAMPLE = 1'b1
    } t_opcode;

endpackage

FILE: hw/rtl/lut3d_bank.sv
// lut3d_bank: one parity bank of the LUT storage, one write and one read port.
// Read data is registered. No package dependency.
`timescale 1ns / 1ps

module lut3d_bank #(
    parameter int DEPTH = 4913,
    parameter int DW    = 51
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DW-1:0]            i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [DW-1:0]            o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/lut3d_trilinear_sampler.sv
// A sample request passes through eight register stages on its way to the result
// strobe; the table read is the fifth of these stages.
// Throughput: one request per clock, write or sample; busy is low except in reset.
// The table sits in eight parity banks so all eight corners read in the same cycle.
// Reset (synchronous, active low) clears lut_size and the pipeline valid bits;
// table contents stay undefined until written. The receiver cannot stall results.
`timescale 1ns / 1ps

module lut3d_trilinear_sampler #(
    parameter int MAX_GRID  = lut3d_pkg::DEF_MAX_GRID,
    parameter int FRAC_BITS = lut3d_pkg::DEF_FRAC_BITS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [lut3d_pkg::SIZE_W-1:0] i_cfg_wdata,
    input  logic                        start,
    output logic                        busy,
    input  logic                        i_opcode,
    input  logic [FRAC_BITS:0]          i_sample_red,
    input  logic [FRAC_BITS:0]          i_sample_green,
    input  logic [FRAC_BITS:0]          i_sample_blue,
    input  logic [lut3d_pkg::IDX_W-1:0] i_entry_red_index,
    input  logic [lut3d_pkg::IDX_W-1:0] i_entry_green_index,
    input  logic [lut3d_pkg::IDX_W-1:0] i_entry_blue_index,
    input  logic [FRAC_BITS:0]          i_entry_red,
    input  logic [FRAC_BITS:0]          i_entry_green,
    input  logic [FRAC_BITS:0]          i_entry_blue,
    output logic                        o_out_valid,
    output logic [FRAC_BITS:0]          o_out_red,
    output logic [FRAC_BITS:0]          o_out_green,
    output logic [FRAC_BITS:0]          o_out_blue
);

    // Widths
    localparam int CW    = FRAC_BITS + 1;              // channel
    localparam int GW    = $clog2(MAX_GRID + 1);       // grid index / size
    localparam int H     = MAX_GRID / 2 + 1;           // bank extent per axis
    localparam int HW    = (H > 1) ? $clog2(H) : 1;
    localparam int DEPTH = H * H * H;
    localparam int AW    = $clog2(DEPTH);
    localparam int SW    = CW + GW;                    // scaled coordinate

    localparam logic [CW-1:0] ONE  = CW'(1) << FRAC_BITS;
    localparam logic [CW-1:0] HALF = ONE >> 1;
    localparam logic [AW-1:0] HA   = AW'(H);

    typedef logic [CW-1:0] t_ch;
    typedef logic [FRAC_BITS-1:0] t_frac;

    function automatic t_ch f_sat(input t_ch v);
        f_sat = (v > ONE) ? ONE : v;
    endfunction

    // (a*(1-t) + b*t + 1/2) >> FRAC; b is dropped when t is zero
    function automatic t_ch f_lerp(input t_ch a, input t_ch b, input t_frac t);
        logic [CW-1:0]   w;
        logic [CW-1:0]   bb;
        logic [2*CW-1:0] p0;
        logic [2*CW-1:0] p1;
        logic [2*CW:0]   acc;
        w   = ONE - {1'b0, t};
        bb  = (t == '0) ? a : b;
        p0  = a * w;
        p1  = bb * {1'b0, t};
        acc = {1'b0, p0} + {1'b0, p1} + (2*CW+1)'(HALF);
        f_lerp = acc[FRAC_BITS +: CW];
    endfunction

    // ---------------- configuration ----------------
    logic [lut3d_pkg::SIZE_W-1:0] r_lut_size;
    logic [GW-1:0]                n_size;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lut_size <= '0;
        end else if (i_cfg_we) begin
            r_lut_size <= i_cfg_wdata;
        end
    end

    // sizes above the grid act as the full grid
    always_comb begin
        if (r_lut_size > MAX_GRID) begin
            n_size = GW'(MAX_GRID);
        end else begin
            n_size = GW'(r_lut_size);
        end
    end

    assign busy = !i_rst_n;

    logic w_acc;
    assign w_acc = start && !busy;

    // ---------------- stage 1: saturate, classify ----------------
    logic          r1_vld, r1_we, r1_pass;
    t_ch           r1_crd [3];
    t_ch           r1_ent [3];
    logic [GW-1:0] r1_wix [3];
    logic [GW-1:0] r1_nm1;
    logic          n1_inrange;

    assign n1_inrange = (n_size >= GW'(2)) &&
                        (i_entry_red_index   < n_size) &&
                        (i_entry_green_index < n_size) &&
                        (i_entry_blue_index  < n_size);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r1_we  <= 1'b0;
        end else begin
            r1_vld <= w_acc && (i_opcode == lut3d_pkg::OP_SAMPLE);
            r1_we  <= w_acc && (i_opcode == lut3d_pkg::OP_WRITE) && n1_inrange;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_pass   <= (n_size < GW'(2));
        r1_nm1    <= n_size - GW'(1);
        r1_crd[0] <= f_sat(i_sample_red);
        r1_crd[1] <= f_sat(i_sample_green);
        r1_crd[2] <= f_sat(i_sample_blue);
        r1_ent[0] <= f_sat(i_entry_red);
        r1_ent[1] <= f_sat(i_entry_green);
        r1_ent[2] <= f_sat(i_entry_blue);
        r1_wix[0] <= GW'(i_entry_red_index);
        r1_wix[1] <= GW'(i_entry_green_index);
        r1_wix[2] <= GW'(i_entry_blue_index);
    end

    // ---------------- stage 2: scale by (size-1) ----------------
    logic          r2_vld, r2_we, r2_pass;
    logic [SW-1:0] r2_scl [3];
    t_ch           r2_crd [3];
    t_ch           r2_ent [3];
    logic [GW-1:0] r2_wix [3];
    logic [GW-1:0] r2_nm1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
            r2_we  <= 1'b0;
        end else begin
            r2_vld <= r1_vld;
            r2_we  <= r1_we;
        end
    end

    always_ff @(posedge i_clk) begin
        r2_pass <= r1_pass;
        r2_nm1  <= r1_nm1;
        for (int i = 0; i < 3; i++) begin
            r2_scl[i] <= SW'(r1_crd[i]) * SW'(r1_nm1);
            r2_crd[i] <= r1_crd[i];
            r2_ent[i] <= r1_ent[i];
            r2_wix[i] <= r1_wix[i];
        end
    end

    // ---------------- stage 3: base cell and fraction ----------------
    logic          r3_vld, r3_we, r3_pass;
    logic [GW-1:0] r3_lo  [3];
    t_frac         r3_fr  [3];
    t_ch           r3_crd [3];
    t_ch           r3_ent [3];
    logic [GW-1:0] r3_wix [3];
    logic [GW:0]   n3_base [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n3_base[i] = r2_scl[i][SW-1:FRAC_BITS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
            r3_we  <= 1'b0;
        end else begin
            r3_vld <= r2_vld;
            r3_we  <= r2_we;
        end
    end

    always_ff @(posedge i_clk) begin
        r3_pass <= r2_pass;
        for (int i = 0; i < 3; i++) begin
            // clamp to last grid point
            r3_lo[i]  <= (n3_base[i] > {1'b0, r2_nm1}) ? r2_nm1 : n3_base[i][GW-1:0];
            r3_fr[i]  <= r2_scl[i][FRAC_BITS-1:0];
            r3_crd[i] <= r2_crd[i];
            r3_ent[i] <= r2_ent[i];
            r3_wix[i] <= r2_wix[i];
        end
    end

    // ---------------- stage 4: bank addresses ----------------
    // Bank k = {b[0], g[0], r[0]}; within a bank the point sits at half coordinates.
    logic          r4_vld, r4_pass;
    logic [AW-1:0] r4_raddr [8];
    logic [7:0]    r4_wen;
    logic [AW-1:0] r4_waddr;
    logic [3*CW-1:0] r4_wdata;
    logic [2:0]    r4_par;
    t_frac         r4_fr  [3];
    t_ch           r4_crd [3];

    logic [HW-1:0] n4_h0 [3];
    logic [HW-1:0] n4_h1 [3];
    logic [GW:0]   n4_up [3];
    logic [AW-1:0] n4_raddr [8];
    logic [HW-1:0] n4_ax [3];
    logic [HW-1:0] n4_wh [3];
    logic [2:0]    n4_wbank;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n4_up[i] = {1'b0, r3_lo[i]} + (GW+1)'(1);
            n4_h0[i] = HW'(r3_lo[i] >> 1);
            n4_h1[i] = HW'(n4_up[i] >> 1);
            n4_wh[i] = HW'(r3_wix[i] >> 1);
        end
        for (int k = 0; k < 8; k++) begin
            for (int i = 0; i < 3; i++) begin
                n4_ax[i] = (k[i] == r3_lo[i][0]) ? n4_h0[i] : n4_h1[i];
            end
            n4_raddr[k] = (AW'(n4_ax[2]) * HA + AW'(n4_ax[1])) * HA + AW'(n4_ax[0]);
        end
        n4_wbank = {r3_wix[2][0], r3_wix[1][0], r3_wix[0][0]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
            r4_wen <= '0;
        end else begin
            r4_vld <= r3_vld;
            for (int k = 0; k < 8; k++) begin
                r4_wen[k] <= r3_we && (n4_wbank == 3'(k));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r4_pass  <= r3_pass;
        r4_waddr <= (AW'(n4_wh[2]) * HA + AW'(n4_wh[1])) * HA + AW'(n4_wh[0]);
        r4_wdata <= {r3_ent[2], r3_ent[1], r3_ent[0]};
        r4_par   <= {r3_lo[2][0], r3_lo[1][0], r3_lo[0][0]};
        for (int k = 0; k < 8; k++) begin
            r4_raddr[k] <= n4_raddr[k];
        end
        for (int i = 0; i < 3; i++) begin
            r4_fr[i]  <= r3_fr[i];
            r4_crd[i] <= r3_crd[i];
        end
    end

    // ---------------- banks (stage 5 read data) ----------------
    logic [3*CW-1:0] w_rd [8];

    for (genvar k = 0; k < 8; k++) begin : g_bank
        lut3d_bank #(
            .DEPTH (DEPTH),
            .DW    (3 * CW)
        ) u_bank (
            .i_clk   (i_clk),
            .i_we    (r4_wen[k]),
            .i_waddr (r4_waddr),
            .i_wdata (r4_wdata),
            .i_raddr (r4_raddr[k]),
            .o_rdata (w_rd[k])
        );
    end

    logic       r5_vld, r5_pass;
    logic [2:0] r5_par;
    t_frac      r5_fr  [3];
    t_ch        r5_crd [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
        end else begin
            r5_vld <= r4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r5_pass <= r4_pass;
        r5_par  <= r4_par;
        for (int i = 0; i < 3; i++) begin
            r5_fr[i]  <= r4_fr[i];
            r5_crd[i] <= r4_crd[i];
        end
    end

    // ---------------- stage 6: lerps along red axis ----------------
    // corner (cx,cy,cz) lives in bank {cz^pz, cy^py, cx^px}
    logic  r6_vld, r6_pass;
    t_ch   r6_c  [3][4];     // [channel][z*2+y]
    t_frac r6_fy, r6_fz;
    t_ch   r6_crd [3];
    t_ch   n6_c  [3][4];
    logic [2:0] n6_b0, n6_b1;

    always_comb begin
        for (int yz = 0; yz < 4; yz++) begin
            n6_b0 = {yz[1] ^ r5_par[2], yz[0] ^ r5_par[1], r5_par[0]};
            n6_b1 = {yz[1] ^ r5_par[2], yz[0] ^ r5_par[1], ~r5_par[0]};
            for (int c = 0; c < 3; c++) begin
                n6_c[c][yz] = f_lerp(w_rd[n6_b0][c*CW +: CW], w_rd[n6_b1][c*CW +: CW],
                                     r5_fr[0]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_vld <= 1'b0;
        end else begin
            r6_vld <= r5_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r6_pass <= r5_pass;
        r6_fy   <= r5_fr[1];
        r6_fz   <= r5_fr[2];
        for (int c = 0; c < 3; c++) begin
            r6_crd[c] <= r5_crd[c];
            for (int yz = 0; yz < 4; yz++) begin
                r6_c[c][yz] <= n6_c[c][yz];
            end
        end
    end

    // ---------------- stage 7: lerps along green axis ----------------
    logic  r7_vld, r7_pass;
    t_ch   r7_c  [3][2];
    t_frac r7_fz;
    t_ch   r7_crd [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_vld <= 1'b0;
        end else begin
            r7_vld <= r6_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r7_pass <= r6_pass;
        r7_fz   <= r6_fz;
        for (int c = 0; c < 3; c++) begin
            r7_crd[c]  <= r6_crd[c];
            r7_c[c][0] <= f_lerp(r6_c[c][0], r6_c[c][1], r6_fy);
            r7_c[c][1] <= f_lerp(r6_c[c][2], r6_c[c][3], r6_fy);
        end
    end

    // ---------------- stage 8: blue axis, pass-through select ----------------
    logic r8_vld;
    t_ch  r8_out [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r8_vld <= 1'b0;
        end else begin
            r8_vld <= r7_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int c = 0; c < 3; c++) begin
            r8_out[c] <= r7_pass ? r7_crd[c] : f_lerp(r7_c[c][0], r7_c[c][1], r7_fz);
        end
    end

    assign o_out_valid = r8_vld;
    assign o_out_red   = r8_out[0];
    assign o_out_green = r8_out[1];
    assign o_out_blue  = r8_out[2];

    // ---------------- assertions ----------------
    // every result traces back to an accepted sample request
    a_out_from_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> $past(start && !busy && (i_opcode == lut3d_pkg::OP_SAMPLE), 8))
        else $error("result without matching sample request");

    // a table write never coincides with a sample read in the memory stage
    a_wr_rd_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r4_wen != '0) |-> !r4_vld)
        else $error("write and sample in memory stage together");

    // at most one bank written per cycle
    a_one_bank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(r4_wen))
        else $error("multiple banks written");

    // results never exceed 1.0
    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_red <= ONE) && (o_out_green <= ONE) && (o_out_blue <= ONE))
        else $error("result above 1.0");

endmodule
